// File: rtl/core/ptab_pkg.sv
package ptab_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int PID_BITS    = 16;
    localparam int IDX_BITS    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);

    // request kinds
    localparam logic [2:0] REQ_ADD_NEW    = 3'd0;
    localparam logic [2:0] REQ_ADD_GIVEN  = 3'd1;
    localparam logic [2:0] REQ_FIND       = 3'd2;
    localparam logic [2:0] REQ_NEXT_READY = 3'd3;
    localparam logic [2:0] REQ_REMOVE     = 3'd4;

    // result status
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_NONE = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;

    localparam logic [1:0] STATE_READY = 2'd1;

    typedef logic [PID_BITS-1:0] pid_t;

    // command broadcast to every cell of the chain
    typedef struct packed {
        logic       find_ready;  // match on ready state instead of id
        pid_t       key;
        logic       shift_en;    // remove: cells at and after the hit take the right neighbor
        logic       add_en;      // append: the selected cell loads add_id/add_state
        pid_t       add_id;
        logic [1:0] add_state;
    } ptab_cmd_t;

endpackage

// File: rtl/core/ptab_cell.sv
module ptab_cell (
    input  logic              aclk,
    input  ptab_pkg::ptab_cmd_t cmd,
    input  logic              occupied,
    input  logic              wr_sel,
    input  logic              hit_in,
    input  ptab_pkg::pid_t    nbr_id,
    input  logic [1:0]        nbr_state,
    output logic              hit_out,
    output logic              first,
    output ptab_pkg::pid_t    cell_id,
    output logic [1:0]        cell_state
);
    import ptab_pkg::*;

    pid_t       id_reg;
    logic [1:0] state_reg;
    logic       match;

    assign match = occupied &&
                   (cmd.find_ready ? (state_reg == STATE_READY) : (id_reg == cmd.key));

    // first hit wins: pass the hit mark on to the right
    assign first   = match && !hit_in;
    assign hit_out = hit_in || match;

    assign cell_id    = id_reg;
    assign cell_state = state_reg;

    always_ff @(posedge aclk) begin
        if (cmd.shift_en && (hit_in || match)) begin
            id_reg    <= nbr_id;
            state_reg <= nbr_state;
        end else if (cmd.add_en && wr_sel) begin
            id_reg    <= cmd.add_id;
            state_reg <= cmd.add_state;
        end
    end

endmodule

// File: rtl/core/process_table_engine.sv
// Channel  Dir  Handshake                  Payload
// s_       in   s_tvalid / s_tready        s_tuser: req_type; s_tdata: key_pid, entry_state
// m_       out  m_tvalid / m_tready        m_tdata: status, result_pid, result_state,
//                                          result_index, entry_count
//
// An item is first captured into the request registers; in the evaluation state the row
// of cells compares all entries at once and the hit mark ripples along the chain.
// The table write (append or shift-down) happens in that same evaluation cycle.
// A result waits in the output register; the next item is accepted meanwhile,
// and its evaluation holds while the output register is still occupied.
// Reset clears the fill count and control state only; entries need none.
module process_table_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [2:0]  s_tuser,   // [2:0] req_type
    input  logic [23:0] s_tdata,   // [15:0] key_pid, [17:16] entry_state, [23:18] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [1:0] status, [17:2] result_pid, [19:18] result_state,
                                   // [23:20] result_index, [28:24] entry_count, [31:29] zero
);
    import ptab_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EVAL = 1'b1;

    logic                state_reg, state_next;
    logic [2:0]          req_reg;
    pid_t                key_reg;
    logic [1:0]          est_reg;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                m_valid_reg, m_valid_next;
    logic [31:0]         m_data_reg, m_data_next;

    logic                s_accept;
    logic                commit;
    logic [31:0]         key_wide;

    ptab_cmd_t           cmd;
    pid_t                cid   [TABLE_DEPTH];
    logic [1:0]          cst   [TABLE_DEPTH];
    logic                first [TABLE_DEPTH];
    logic                occ   [TABLE_DEPTH];
    logic                wsel  [TABLE_DEPTH];
    logic                hit   [TABLE_DEPTH+1];

    pid_t                sel_id, last_id, new_id;
    logic [1:0]          sel_st;
    logic [IDX_BITS-1:0] sel_idx;
    logic                found, full, is_add;

    logic [1:0]          r_status;
    pid_t                r_pid;
    logic [1:0]          r_state;
    logic [IDX_BITS-1:0] r_idx;
    logic [31:0]         pid_wide, idx_wide, cnt_wide;

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    // evaluate only when the output register can take the result
    assign commit   = (state_reg == S_EVAL) && (!m_valid_reg || m_tready);
    assign key_wide = 32'(s_tdata[15:0]);

    assign full   = (count_reg == CNT_BITS'(TABLE_DEPTH));
    assign is_add = (req_reg == REQ_ADD_NEW) || (req_reg == REQ_ADD_GIVEN);

    // per-cell occupancy and append slot
    always_comb begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            occ[i]  = (CNT_BITS'(i) < count_reg);
            wsel[i] = (CNT_BITS'(i) == count_reg);
        end
    end

    // gather hit entry and last entry from the row (one-hot AND-OR)
    always_comb begin
        sel_id  = '0;
        sel_st  = '0;
        sel_idx = '0;
        last_id = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (first[i]) begin
                sel_id  = sel_id | cid[i];
                sel_st  = sel_st | cst[i];
                sel_idx = sel_idx | IDX_BITS'(i);
            end
            if (CNT_BITS'(i + 1) == count_reg) begin
                last_id = last_id | cid[i];
            end
        end
    end

    assign found  = hit[TABLE_DEPTH];
    assign new_id = (count_reg == '0) ? '0 : last_id + 1'b1;

    always_comb begin
        cmd.find_ready = (req_reg == REQ_NEXT_READY);
        cmd.key        = key_reg;
        cmd.shift_en   = commit && (req_reg == REQ_REMOVE);
        cmd.add_en     = commit && is_add && !full;
        cmd.add_id     = (req_reg == REQ_ADD_NEW) ? new_id : key_reg;
        cmd.add_state  = (req_reg == REQ_ADD_NEW) ? STATE_READY : est_reg;
    end

    assign hit[0] = 1'b0;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        pid_t       right_id;
        logic [1:0] right_st;
        if (g == TABLE_DEPTH - 1) begin : g_end
            // last cell has no right neighbor: keep its own contents
            assign right_id = cid[g];
            assign right_st = cst[g];
        end else begin : g_mid
            assign right_id = cid[g+1];
            assign right_st = cst[g+1];
        end
        ptab_cell u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .occupied   (occ[g]),
            .wr_sel     (wsel[g]),
            .hit_in     (hit[g]),
            .nbr_id     (right_id),
            .nbr_state  (right_st),
            .hit_out    (hit[g+1]),
            .first      (first[g]),
            .cell_id    (cid[g]),
            .cell_state (cst[g])
        );
    end

    // result of the request under evaluation
    always_comb begin
        r_status   = STAT_NONE;
        r_pid      = '0;
        r_state    = '0;
        r_idx      = '0;
        count_next = count_reg;
        case (req_reg)
            REQ_ADD_NEW, REQ_ADD_GIVEN: begin
                if (full) begin
                    r_status = STAT_FULL;
                end else begin
                    r_status   = STAT_OK;
                    r_pid      = cmd.add_id;
                    r_state    = cmd.add_state;
                    r_idx      = count_reg[IDX_BITS-1:0];
                    count_next = count_reg + 1'b1;
                end
            end
            REQ_FIND, REQ_NEXT_READY: begin
                if (found) begin
                    r_status = STAT_OK;
                    r_pid    = sel_id;
                    r_state  = sel_st;
                    r_idx    = sel_idx;
                end
            end
            REQ_REMOVE: begin
                if (found) begin
                    r_status   = STAT_OK;
                    r_pid      = sel_id;
                    r_state    = sel_st;
                    r_idx      = sel_idx;
                    count_next = count_reg - 1'b1;
                end
            end
            default: begin
                r_status = STAT_NONE;
            end
        endcase
    end

    assign pid_wide = 32'(r_pid);
    assign idx_wide = 32'(r_idx);
    assign cnt_wide = 32'(count_next);

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        // drop the result once taken
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (s_accept) begin
            state_next = S_EVAL;
        end
        if (commit) begin
            state_next   = S_IDLE;
            m_valid_next = 1'b1;
            m_data_next  = {3'b000, cnt_wide[4:0], idx_wide[3:0], r_state,
                            pid_wide[15:0], r_status};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (commit) begin
                count_reg <= count_next;
            end
        end
    end

    // payload: no reset
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (s_accept) begin
            req_reg <= s_tuser;
            key_reg <= key_wide[PID_BITS-1:0];
            est_reg <= s_tdata[17:16];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTHESIS
    // an accepted item always moves into evaluation
    a_accept_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == S_EVAL))
        else $error("accepted item did not enter evaluation");

    // fill count stays within the table
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_BITS'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    // a successful append grows the table by exactly one
    a_add_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && is_add && !full) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("append did not grow the table");

    // a result is loaded only when the output register is free or draining
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready && (state_reg == S_EVAL)) |=> $stable(count_reg))
        else $error("evaluation ran while the result was stalled");
`endif

endmodule
